FILE: hw/rtl/dpms_pkg.sv
// ----------------------------------------------------------------------------
// dpms_pkg
// Shared codes and types for the dense pool mark/sweep core.
// ----------------------------------------------------------------------------
package dpms_pkg;

  localparam int OP_BITS = 3;
  localparam logic [OP_BITS-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_BITS-1:0] OP_WRITE_PAY = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SET_TYPE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_MARK_DEAD = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SWEEP     = 3'd4;
  localparam logic [OP_BITS-1:0] OP_READ      = 3'd5;

  localparam int STATUS_BITS = 2;
  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_LIVE = 2'd2;

  localparam int TYPE_BITS      = 7;
  localparam int TYPE_WORD_BITS = 8;
  localparam int DEAD_POS       = 7;
  localparam logic [TYPE_WORD_BITS-1:0] DEAD_MASK = 8'h80;
  localparam logic [TYPE_WORD_BITS-1:0] TYPE_MASK = 8'h7f;

  // write enables toward the entry memories
  typedef struct packed {
    logic type_we;
    logic pay_we;
  } wr_en_t;

endpackage

FILE: hw/rtl/dense_pool_mark_sweep_core.sv
// ----------------------------------------------------------------------------
// dense_pool_mark_sweep_core
// Packed entry table with allocate, payload write, retype, dead marking,
// compacting sweep and read, built around one read/one write entry memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result
// appears with done high for exactly one cycle and cannot be held off, so
// the receiver must take it then. Alloc, write payload, set type, mark dead,
// read and the unused codes do one memory read, then modify and write back,
// and no new command is taken while one is in progress. Sweep walks the
// entries in use through the single memory read port: each live entry is
// read and checked, each dead entry is refilled from the end of the table
// and checked again, and a dead last entry is just dropped. The result
// always reports the live count and the free slots after the command.
module dense_pool_mark_sweep_core #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [dpms_pkg::OP_BITS-1:0]           opcode,
  input  logic [$clog2(CAPACITY)-1:0]            slot_index,
  input  logic [dpms_pkg::TYPE_BITS-1:0]         type_value,
  input  logic [PAYLOAD_BITS-1:0]                payload_in,
  output logic                                   done,
  output logic [dpms_pkg::STATUS_BITS-1:0]       status,
  output logic [$clog2(CAPACITY)-1:0]            slot_out,
  output logic [dpms_pkg::TYPE_BITS-1:0]         type_out,
  output logic                                   dead_out,
  output logic [PAYLOAD_BITS-1:0]                payload_out,
  output logic [$clog2(CAPACITY+1)-1:0]          live_count,
  output logic [$clog2(CAPACITY+1)-1:0]          free_slots
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TWB = dpms_pkg::TYPE_WORD_BITS;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SW_RD  = 3'd2;
  localparam logic [2:0] S_SW_CHK = 3'd3;
  localparam logic [2:0] S_SW_CP  = 3'd4;

  logic [2:0]  state, state_next;
  logic [CW-1:0] used, used_next;
  logic [CW-1:0] cur, cur_next;
  logic [CW-1:0] last, last_next;
  logic [CW-1:0] last_m1;

  logic [dpms_pkg::OP_BITS-1:0]   op;
  logic [SW-1:0]                  slot;
  logic [dpms_pkg::TYPE_BITS-1:0] tval;
  logic [PAYLOAD_BITS-1:0]        pay;

  logic            accept;
  logic            live;
  logic [SW-1:0]   rd_addr;
  logic [TWB-1:0]  rd_type;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  dpms_pkg::wr_en_t wr_en;
  logic [SW-1:0]   wr_addr;
  logic [TWB-1:0]  wr_type;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  logic                             res_valid;
  logic [dpms_pkg::STATUS_BITS-1:0] res_status;
  logic [SW-1:0]                    res_slot;
  logic [dpms_pkg::TYPE_BITS-1:0]   res_type;
  logic                             res_dead;
  logic [PAYLOAD_BITS-1:0]          res_pay;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign live    = (CW'(slot) < used);
  assign last_m1 = last - CW'(1);

  dpms_mem #(
    .DEPTH (CAPACITY),
    .AW    (SW),
    .PW    (PAYLOAD_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_type (rd_type),
    .rd_pay  (rd_pay),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_type (wr_type),
    .wr_pay  (wr_pay)
  );

  // read address: command slot on transfer, walk pointers during sweep
  always_comb begin
    unique case (state)
      S_IDLE:   rd_addr = slot_index;
      S_SW_RD:  rd_addr = cur[SW-1:0];
      S_SW_CHK: rd_addr = last_m1[SW-1:0];
      default:  rd_addr = slot;
    endcase
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    cur_next   = cur;
    last_next  = last;
    wr_en      = '0;
    wr_addr    = slot;
    wr_type    = rd_type;
    wr_pay     = pay;
    res_valid  = 1'b0;
    res_status = dpms_pkg::STATUS_OK;
    res_slot   = '0;
    res_type   = '0;
    res_dead   = 1'b0;
    res_pay    = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next  = '0;
          last_next = used;
          state_next = (opcode == dpms_pkg::OP_SWEEP) ? S_SW_RD : S_EXEC;
        end
      end

      S_EXEC: begin
        res_valid  = 1'b1;
        state_next = S_IDLE;
        case (op)
          dpms_pkg::OP_ALLOC: begin
            if (used == CAP_COUNT) begin
              res_status = dpms_pkg::STATUS_FULL;
            end else begin
              wr_en.type_we = 1'b1;
              wr_addr   = used[SW-1:0];
              wr_type   = '0;
              res_slot  = used[SW-1:0];
              used_next = used + CW'(1);
            end
          end
          dpms_pkg::OP_WRITE_PAY: begin
            if (!live) begin
              res_status = dpms_pkg::STATUS_NOT_LIVE;
            end else begin
              wr_en.pay_we = 1'b1;
            end
          end
          dpms_pkg::OP_SET_TYPE: begin
            if (!live) begin
              res_status = dpms_pkg::STATUS_NOT_LIVE;
            end else begin
              wr_en.type_we = 1'b1;
              wr_type = (rd_type & dpms_pkg::DEAD_MASK) | {1'b0, tval};
            end
          end
          dpms_pkg::OP_MARK_DEAD: begin
            if (!live) begin
              res_status = dpms_pkg::STATUS_NOT_LIVE;
            end else begin
              wr_en.type_we = 1'b1;
              wr_type = rd_type | dpms_pkg::DEAD_MASK;
            end
          end
          dpms_pkg::OP_READ: begin
            if (!live) begin
              res_status = dpms_pkg::STATUS_NOT_LIVE;
            end else begin
              res_slot = slot;
              res_type = rd_type[dpms_pkg::TYPE_BITS-1:0];
              res_dead = rd_type[dpms_pkg::DEAD_POS];
              res_pay  = rd_pay;
            end
          end
          default: begin
          end
        endcase
      end

      S_SW_RD: begin
        if (cur >= last) begin
          used_next  = last;
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SW_CHK;
        end
      end

      S_SW_CHK: begin
        if (!rd_type[dpms_pkg::DEAD_POS]) begin
          cur_next   = cur + CW'(1);
          state_next = S_SW_RD;
        end else if (cur == last_m1) begin
          // dead entry is the last one: just drop it
          last_next  = last_m1;
          state_next = S_SW_RD;
        end else begin
          state_next = S_SW_CP;
        end
      end

      S_SW_CP: begin
        // fill the hole with the last entry, then check the slot again
        wr_en.type_we = 1'b1;
        wr_en.pay_we  = 1'b1;
        wr_addr    = cur[SW-1:0];
        wr_type    = rd_type;
        wr_pay     = rd_pay;
        last_next  = last_m1;
        state_next = S_SW_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      cur   <= '0;
      last  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      cur   <= cur_next;
      last  <= last_next;
      done  <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= opcode;
      slot <= slot_index;
      tval <= type_value;
      pay  <= payload_in;
    end
    if (res_valid) begin
      status      <= res_status;
      slot_out    <= res_slot;
      type_out    <= res_type;
      dead_out    <= res_dead;
      payload_out <= res_pay;
      live_count  <= used_next;
      free_slots  <= CAP_COUNT - used_next;
    end
  end

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CAP_COUNT)
    else $error("live count exceeds capacity");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result strobe without a command in progress");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_CHK || state == S_SW_CP) |-> (cur < last && last <= used))
    else $error("sweep pointers out of order");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, live_count} + {1'b0, free_slots}) == (CW + 1)'(CAPACITY))
    else $error("live count and free slots disagree");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("not busy after command transfer");
`endif

endmodule

FILE: hw/rtl/dpms_mem.sv
// ----------------------------------------------------------------------------
// dpms_mem
// Entry storage: type word memory and payload memory, one shared write
// address and one shared read address, read data registered.
// ----------------------------------------------------------------------------
module dpms_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int PW    = 32
) (
  input  logic                                clk,
  input  logic [AW-1:0]                       rd_addr,
  output logic [dpms_pkg::TYPE_WORD_BITS-1:0] rd_type,
  output logic [PW-1:0]                       rd_pay,
  input  dpms_pkg::wr_en_t                    wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic [dpms_pkg::TYPE_WORD_BITS-1:0] wr_type,
  input  logic [PW-1:0]                       wr_pay
);

  logic [dpms_pkg::TYPE_WORD_BITS-1:0] type_mem [DEPTH];
  logic [PW-1:0]                       pay_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.type_we) begin
      type_mem[wr_addr] <= wr_type;
    end
    if (wr_en.pay_we) begin
      pay_mem[wr_addr] <= wr_pay;
    end
    rd_type <= type_mem[rd_addr];
    rd_pay  <= pay_mem[rd_addr];
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dense_pool_mark_sweep_core. Commands are issued on
// the start/busy transfer, and every accepted command runs through a local
// model of the packed table to work out the one result it causes. Each done
// strobe is compared with the oldest pending result. A short table of directed
// commands comes first, then about 800 random ones. The random part moves
// between filling and draining the table, in three phases that idle at different rates.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_BITS    = $clog2(CAPACITY);
  localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

  localparam logic [dpms_pkg::OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [dpms_pkg::OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_CMDS  = 800;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_GAP      = 20;

  typedef struct packed {
    logic [dpms_pkg::STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]             slot;
    logic [dpms_pkg::TYPE_BITS-1:0]   kind;
    logic                             dead;
    logic [PAYLOAD_BITS-1:0]          payload;
    logic [COUNT_BITS-1:0]            live;
    logic [COUNT_BITS-1:0]            free;
  } pool_result_t;

  typedef struct packed {
    logic [dpms_pkg::OP_BITS-1:0]   op;
    logic [SLOT_BITS-1:0]           slot;
    logic [dpms_pkg::TYPE_BITS-1:0] tval;
    logic [PAYLOAD_BITS-1:0]        payload;
    logic [7:0]                     repeats;
    logic                           fixed;
    pool_result_t                   want;
  } pool_cmd_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [dpms_pkg::OP_BITS-1:0]     opcode = dpms_pkg::OP_ALLOC;
  logic [SLOT_BITS-1:0]             slot_index = '0;
  logic [dpms_pkg::TYPE_BITS-1:0]   type_value = '0;
  logic [PAYLOAD_BITS-1:0]          payload_in = '0;
  logic                             done;
  logic [dpms_pkg::STATUS_BITS-1:0] status;
  logic [SLOT_BITS-1:0]             slot_out;
  logic [dpms_pkg::TYPE_BITS-1:0]   type_out;
  logic                             dead_out;
  logic [PAYLOAD_BITS-1:0]          payload_out;
  logic [COUNT_BITS-1:0]            live_count;
  logic [COUNT_BITS-1:0]            free_slots;

  dense_pool_mark_sweep_core #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .slot_index (slot_index),
    .type_value (type_value),
    .payload_in (payload_in),
    .done       (done),
    .status     (status),
    .slot_out   (slot_out),
    .type_out   (type_out),
    .dead_out   (dead_out),
    .payload_out(payload_out),
    .live_count (live_count),
    .free_slots (free_slots)
  );

  always #5 clk = ~clk;

  // Table model: type words, payloads, and whether a payload was ever stored
  logic [dpms_pkg::TYPE_WORD_BITS-1:0] model_types [CAPACITY];
  logic [PAYLOAD_BITS-1:0]             model_payloads [CAPACITY];
  bit                                  payload_known [CAPACITY];
  int unsigned                         model_used = 0;

  pool_result_t expected_results [$];
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // Fill each dead entry from the tail and revisit it; one visit per entry
  // that was in use when the sweep began.
  function automatic void compact_pool();
    int unsigned cur;
    int unsigned last;
    int unsigned visits;
    cur = 0;
    last = model_used;
    visits = model_used;
    while (visits > 0) begin
      visits--;
      if ((model_types[cur] & dpms_pkg::DEAD_MASK) != '0) begin
        if (visits > 0 && last >= 1) begin
          model_types[cur]    = model_types[last-1];
          model_payloads[cur] = model_payloads[last-1];
          payload_known[cur]  = payload_known[last-1];
        end
        last--;
      end else begin
        cur++;
      end
    end
    model_used = last;
  endfunction

  function automatic pool_result_t pool_apply(input logic [dpms_pkg::OP_BITS-1:0] op,
                                              input logic [SLOT_BITS-1:0] slot,
                                              input logic [dpms_pkg::TYPE_BITS-1:0] tval,
                                              input logic [PAYLOAD_BITS-1:0] payload);
    pool_result_t r;
    bit           live;
    r = '0;
    live = 32'(slot) < model_used;
    case (op)
      dpms_pkg::OP_ALLOC: begin
        if (model_used >= CAPACITY) begin
          r.status = dpms_pkg::STATUS_FULL;
        end else begin
          r.slot = SLOT_BITS'(model_used);
          model_types[model_used] = '0;
          model_used++;
        end
      end
      dpms_pkg::OP_WRITE_PAY: begin
        if (!live) begin
          r.status = dpms_pkg::STATUS_NOT_LIVE;
        end else begin
          model_payloads[slot] = payload;
          payload_known[slot]  = 1'b1;
        end
      end
      dpms_pkg::OP_SET_TYPE: begin
        if (!live) r.status = dpms_pkg::STATUS_NOT_LIVE;
        else model_types[slot] = (model_types[slot] & dpms_pkg::DEAD_MASK) | {1'b0, tval};
      end
      dpms_pkg::OP_MARK_DEAD: begin
        if (!live) r.status = dpms_pkg::STATUS_NOT_LIVE;
        else model_types[slot] = model_types[slot] | dpms_pkg::DEAD_MASK;
      end
      dpms_pkg::OP_SWEEP: compact_pool();
      dpms_pkg::OP_READ: begin
        if (!live) begin
          r.status = dpms_pkg::STATUS_NOT_LIVE;
        end else begin
          r.slot    = slot;
          r.kind    = model_types[slot][dpms_pkg::TYPE_BITS-1:0];
          r.dead    = model_types[slot][dpms_pkg::DEAD_POS];
          r.payload = model_payloads[slot];
        end
      end
      default: ;
    endcase
    r.live = COUNT_BITS'(model_used);
    r.free = COUNT_BITS'(CAPACITY - model_used);
    return r;
  endfunction

  function automatic pool_cmd_t pool_cmd(input logic [dpms_pkg::OP_BITS-1:0] op,
                                         input int slot,
                                         input int tval,
                                         input logic [PAYLOAD_BITS-1:0] payload,
                                         input int repeats = 1);
    pool_cmd_t c;
    c = '0;
    c.op      = op;
    c.slot    = SLOT_BITS'(slot);
    c.tval    = dpms_pkg::TYPE_BITS'(tval);
    c.payload = payload;
    c.repeats = 8'(repeats);
    return c;
  endfunction

  function automatic pool_cmd_t with_result(input pool_cmd_t c,
                                            input logic [dpms_pkg::STATUS_BITS-1:0] st,
                                            input int slot, input int kind, input bit dead,
                                            input logic [PAYLOAD_BITS-1:0] payload,
                                            input int live);
    pool_cmd_t r;
    r = c;
    r.fixed        = 1'b1;
    r.want.status  = st;
    r.want.slot    = SLOT_BITS'(slot);
    r.want.kind    = dpms_pkg::TYPE_BITS'(kind);
    r.want.dead    = dead;
    r.want.payload = payload;
    r.want.live    = COUNT_BITS'(live);
    r.want.free    = COUNT_BITS'(CAPACITY - live);
    return r;
  endfunction

  function automatic string describe(input pool_result_t r);
    return $sformatf("status=%0d slot=%0d type=%0h dead=%0d payload=%h live=%0d free=%0d",
                     r.status, r.slot, r.kind, r.dead, r.payload, r.live, r.free);
  endfunction

  task automatic note_error(input string msg);
    if (mismatches < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Hold start high across back-to-back commands; drop it only for a gap.
  task automatic issue(input pool_cmd_t c, input int idle_pct);
    int           gap;
    pool_result_t predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= c.op;
    slot_index <= c.slot;
    type_value <= c.tval;
    payload_in <= c.payload;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = pool_apply(c.op, c.slot, c.tval, c.payload);
    expected_results.push_back(c.fixed ? c.want : predicted);
  endtask

  always @(posedge clk) begin : result_check
    pool_result_t got;
    pool_result_t want;
    if (!rst && done) begin
      got = {status, slot_out, type_out, dead_out, payload_out, live_count, free_slots};
      if (expected_results.size() == 0) begin
        note_error({"result with nothing pending: ", describe(got)});
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          note_error({"mismatch\n  expected ", describe(want), "\n  actual   ", describe(got)});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    pool_cmd_t plan [$];
    pool_cmd_t c;
    int        alloc_pct;
    int        idle_pct;
    int        pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused codes
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_READ, 0, 0, '0),
                               dpms_pkg::STATUS_NOT_LIVE, 0, 0, 0, '0, 0));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_SWEEP, 0, 0, '0),
                               dpms_pkg::STATUS_OK, 0, 0, 0, '0, 0));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_MARK_DEAD, 63, 127, '1),
                               dpms_pkg::STATUS_NOT_LIVE, 0, 0, 0, '0, 0));
    plan.push_back(with_result(pool_cmd(OP_SPARE_6, 63, 127, '1),
                               dpms_pkg::STATUS_OK, 0, 0, 0, '0, 0));
    plan.push_back(with_result(pool_cmd(OP_SPARE_7, 63, 127, '1),
                               dpms_pkg::STATUS_OK, 0, 0, 0, '0, 0));
    // one entry: write, retype, mark twice, retype while dead
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_ALLOC, 0, 0, '0),
                               dpms_pkg::STATUS_OK, 0, 0, 0, '0, 1));
    plan.push_back(pool_cmd(dpms_pkg::OP_WRITE_PAY, 0, 0, 32'hffff_ffff));
    plan.push_back(pool_cmd(dpms_pkg::OP_SET_TYPE, 0, 127, '0));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_READ, 0, 0, '0), dpms_pkg::STATUS_OK,
                               0, 127, 0, 32'hffff_ffff, 1));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_WRITE_PAY, 1, 0, '0),
                               dpms_pkg::STATUS_NOT_LIVE, 0, 0, 0, '0, 1));
    plan.push_back(pool_cmd(dpms_pkg::OP_MARK_DEAD, 0, 0, '0));
    plan.push_back(pool_cmd(dpms_pkg::OP_MARK_DEAD, 0, 0, '0));
    plan.push_back(pool_cmd(dpms_pkg::OP_SET_TYPE, 0, 0, '0));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_READ, 0, 0, '0), dpms_pkg::STATUS_OK,
                               0, 0, 1, 32'hffff_ffff, 1));
    plan.push_back(pool_cmd(dpms_pkg::OP_WRITE_PAY, 0, 0, '0));
    // dead last entry drops without a copy
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_SWEEP, 0, 0, '0),
                               dpms_pkg::STATUS_OK, 0, 0, 0, '0, 0));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_READ, 0, 0, '0),
                               dpms_pkg::STATUS_NOT_LIVE, 0, 0, 0, '0, 0));
    // full table, then refill holes from the tail
    plan.push_back(pool_cmd(dpms_pkg::OP_ALLOC, 0, 0, '0, CAPACITY));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_ALLOC, 0, 0, '0), dpms_pkg::STATUS_FULL,
                               0, 0, 0, '0, CAPACITY));
    plan.push_back(pool_cmd(dpms_pkg::OP_WRITE_PAY, 63, 0, 32'ha5a5_5a5a));
    plan.push_back(pool_cmd(dpms_pkg::OP_SET_TYPE, 63, 'h55, '0));
    plan.push_back(pool_cmd(dpms_pkg::OP_MARK_DEAD, 0, 0, '0));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_READ, 63, 0, '0), dpms_pkg::STATUS_OK,
                               63, 'h55, 0, 32'ha5a5_5a5a, CAPACITY));
    plan.push_back(pool_cmd(dpms_pkg::OP_MARK_DEAD, 62, 0, '0));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_SWEEP, 0, 0, '0),
                               dpms_pkg::STATUS_OK, 0, 0, 0, '0, 62));
    plan.push_back(with_result(pool_cmd(dpms_pkg::OP_READ, 0, 0, '0), dpms_pkg::STATUS_OK,
                               0, 'h55, 0, 32'ha5a5_5a5a, 62));

    foreach (plan[i]) repeat (plan[i].repeats) issue(plan[i], 16);

    alloc_pct = 25;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // swing the table between filling up and draining
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: alloc_pct = 8;
          1: alloc_pct = 25;
          default: alloc_pct = 55;
        endcase
      end
      if (n < RANDOM_CMDS / 3) idle_pct = 16;
      else if (n < 2 * RANDOM_CMDS / 3) idle_pct = 50;
      else idle_pct = 0;

      c = pool_cmd(OP_SPARE_7, int'($urandom_range(0, CAPACITY - 1)),
                   int'($urandom_range(0, 127)), $urandom());
      if (model_used > 0 && $urandom_range(0, 99) < 85)
        c.slot = SLOT_BITS'($urandom_range(0, model_used - 1));
      pick = int'($urandom_range(0, 99));
      if (pick < alloc_pct) begin
        c.op = dpms_pkg::OP_ALLOC;
      end else begin
        pick = int'($urandom_range(0, 99));
        if (pick < 25) c.op = dpms_pkg::OP_WRITE_PAY;
        else if (pick < 40) c.op = dpms_pkg::OP_SET_TYPE;
        else if (pick < 58) c.op = dpms_pkg::OP_MARK_DEAD;
        else if (pick < 66) c.op = dpms_pkg::OP_SWEEP;
        else if (pick < 94) c.op = dpms_pkg::OP_READ;
        else if (pick < 97) c.op = OP_SPARE_6;
      end
      // store a payload before it can be read back
      if (c.op == dpms_pkg::OP_READ && 32'(c.slot) < model_used && !payload_known[c.slot])
        c.op = dpms_pkg::OP_WRITE_PAY;
      issue(c, idle_pct);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
